### src/lsmt_pkg.sv
// ----------------------------------------------------------------------------
// lsmt_pkg
// Shared types and constants for the LCD scanline and mode timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsmt_pkg;

  localparam int unsigned CountW  = 11;
  localparam int unsigned LineW   = 8;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned CfgIdxW = 2;

  // First line of vertical blank and last line of the frame.
  localparam logic [LineW-1:0] VblankLine = 8'd144;
  localparam logic [LineW-1:0] LastLine   = 8'd153;

  // Reset values of the timing registers.
  localparam logic [CfgW-1:0] CplReset    = 10'd456;
  localparam logic [CfgW-1:0] OamEndReset = 10'd80;
  localparam logic [CfgW-1:0] XferEndReset = 10'd252;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLOR_MODE      = 2'd0,
    REG_CYCLES_PER_LINE = 2'd1,
    REG_OAM_SEARCH_END  = 2'd2,
    REG_TRANSFER_END    = 2'd3
  } cfg_idx_e;

  // STAT enable bit positions.
  localparam int unsigned EnHblank = 0;
  localparam int unsigned EnVblank = 1;
  localparam int unsigned EnOam    = 2;
  localparam int unsigned EnLyc    = 3;

  typedef struct packed {
    logic            color_mode;
    logic [CfgW-1:0] cycles_per_line;
    logic [CfgW-1:0] oam_search_end;
    logic [CfgW-1:0] transfer_end;
  } cfg_t;

  typedef struct packed {
    logic [7:0] cycles;
    logic [7:0] lcdc;
    logic [3:0] stat_enables;
    logic [7:0] lyc;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ly;
    logic [1:0] mode;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_request;
    logic [2:0] draw_layers;
    logic       obj_tall;
    logic [2:0] region_select;
  } out_word_t;

endpackage

`default_nettype wire

### src/lcd_scanline_mode_timer_top.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer_top
// Scanline and mode timer for a handheld-style LCD. Each input word carries
// the CPU time elapsed since the last word plus the LCD control byte, the
// STAT interrupt enables and the line compare value. The block classifies
// the current mode (vblank from line 144, else OAM search / pixel transfer /
// hblank by cycle thresholds), flags line==compare, pulses the STAT
// interrupt on entry into an enabled mode or on an enabled coincidence,
// then adds the cycles and advances the line at each line boundary. Lines
// 1..143 request a draw with the layer and map selects decoded from the
// control byte; line 144 pulses vblank; the line wraps to 0 after 153.
// With display enable (control bit 7) low the count and line clear and the
// mode reads vblank. Throughput is one word per clock while out_ready_i is
// high; each word passes the input register, then the result register,
// and the per-word work is one 11-bit add, one subtract and a few
// compares. Timing registers (color_mode, cycles_per_line, oam_search_end,
// transfer_end) are written through a plain write port and should only be
// changed while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_scanline_mode_timer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [lsmt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lsmt_pkg::CfgW-1:0]      cfg_wdata_i,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire lsmt_pkg::in_word_t             in_data_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output lsmt_pkg::out_word_t                 out_data_o
);

  lsmt_pkg::cfg_t     cfg;
  logic               s_valid;
  logic               s_ready;
  lsmt_pkg::in_word_t s_data;

  // Timing registers.
  lsmt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage 1: register the incoming word.
  lsmt_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .s_valid_o  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_o   (s_data)
  );

  // Stage 2: update timer state and load the result register.
  // State only moves when a word enters the result register, so ordering
  // across stalls is preserved.
  lsmt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_valid),
    .s_ready_o   (s_ready),
    .s_data_i    (s_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### src/lsmt_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsmt_cfg_regs
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmt_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lsmt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lsmt_pkg::CfgW-1:0]      cfg_wdata_i,
  output lsmt_pkg::cfg_t                      cfg_o
);

  lsmt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lsmt_pkg::cfg_idx_e'(cfg_idx_i))
        lsmt_pkg::REG_COLOR_MODE:      cfg_d.color_mode      = cfg_wdata_i[0];
        lsmt_pkg::REG_CYCLES_PER_LINE: cfg_d.cycles_per_line = cfg_wdata_i;
        lsmt_pkg::REG_OAM_SEARCH_END:  cfg_d.oam_search_end  = cfg_wdata_i;
        lsmt_pkg::REG_TRANSFER_END:    cfg_d.transfer_end    = cfg_wdata_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode      <= 1'b0;
      cfg_q.cycles_per_line <= lsmt_pkg::CplReset;
      cfg_q.oam_search_end  <= lsmt_pkg::OamEndReset;
      cfg_q.transfer_end    <= lsmt_pkg::XferEndReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/lsmt_in_reg.sv
// ----------------------------------------------------------------------------
// lsmt_in_reg
// Input pipeline register; takes a new word when empty or whenever the next stage drains.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmt_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lsmt_pkg::in_word_t in_data_i,
  output logic                    s_valid_o,
  input  wire logic               s_ready_i,
  output lsmt_pkg::in_word_t      s_data_o
);

  logic               valid_q;
  lsmt_pkg::in_word_t data_q;

  assign in_ready_o = !valid_q || s_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign s_valid_o = valid_q;
  assign s_data_o  = data_q;

endmodule

`default_nettype wire

### src/lsmt_core.sv
// ----------------------------------------------------------------------------
// lsmt_core
// Timer state, mode classify, interrupt decode and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmt_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lsmt_pkg::cfg_t     cfg_i,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire lsmt_pkg::in_word_t s_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lsmt_pkg::out_word_t     out_data_o
);

  logic [lsmt_pkg::CountW-1:0] count_q, count_d;
  logic [lsmt_pkg::LineW-1:0]  line_q, line_d;
  lsmt_pkg::mode_e             mode_q, mode_d;
  logic                        coin_q, coin_d;
  logic                        out_valid_q;
  lsmt_pkg::out_word_t         out_q, out_d;

  logic                        take;
  logic                        wants;
  lsmt_pkg::mode_e             new_mode;
  logic [lsmt_pkg::CountW:0]   sum;
  logic [lsmt_pkg::CountW-1:0] wrapped;
  logic [lsmt_pkg::CountW-1:0] cpl;
  logic [lsmt_pkg::LineW-1:0]  next_line;

  assign s_ready_o = !out_valid_q || out_ready_i;
  assign take      = s_valid_i && s_ready_o;

  assign cpl       = {1'b0, cfg_i.cycles_per_line};
  assign sum       = {1'b0, count_q} + {4'b0, s_data_i.cycles};
  assign wrapped   = sum[lsmt_pkg::CountW-1:0];
  assign next_line = line_q + 8'd1;

  always_comb begin
    new_mode = lsmt_pkg::MODE_HBLANK;
    wants    = 1'b0;
    priority if (line_q >= lsmt_pkg::VblankLine) begin
      new_mode = lsmt_pkg::MODE_VBLANK;
      wants    = s_data_i.stat_enables[lsmt_pkg::EnVblank];
    end else if (count_q <= {1'b0, cfg_i.oam_search_end}) begin
      new_mode = lsmt_pkg::MODE_OAM;
      wants    = s_data_i.stat_enables[lsmt_pkg::EnOam];
    end else if (count_q <= {1'b0, cfg_i.transfer_end}) begin
      new_mode = lsmt_pkg::MODE_XFER;
    end else begin
      new_mode = lsmt_pkg::MODE_HBLANK;
      wants    = s_data_i.stat_enables[lsmt_pkg::EnHblank];
    end
  end

  always_comb begin
    count_d = count_q;
    line_d  = line_q;
    mode_d  = mode_q;
    coin_d  = coin_q;
    out_d   = '0;

    if (!s_data_i.lcdc[7]) begin
      count_d = '0;
      line_d  = '0;
      mode_d  = lsmt_pkg::MODE_VBLANK;
    end else begin
      mode_d = new_mode;
      coin_d = (line_q == s_data_i.lyc);
      out_d.stat_irq = ((new_mode != mode_q) && wants) ||
                       (coin_d && s_data_i.stat_enables[lsmt_pkg::EnLyc]);
      count_d = wrapped;
      if (wrapped >= cpl) begin
        count_d = wrapped - cpl;
        line_d  = next_line;
        priority if (next_line < lsmt_pkg::VblankLine) begin
          out_d.draw_request  = 1'b1;
          out_d.draw_layers   = {s_data_i.lcdc[5], s_data_i.lcdc[1],
                                 cfg_i.color_mode | s_data_i.lcdc[0]};
          out_d.obj_tall      = s_data_i.lcdc[2];
          out_d.region_select = {s_data_i.lcdc[6], s_data_i.lcdc[4], s_data_i.lcdc[3]};
        end else if (next_line == lsmt_pkg::VblankLine) begin
          out_d.vblank_irq = 1'b1;
        end else if (next_line > lsmt_pkg::LastLine) begin
          line_d = '0;
        end else begin
          line_d = next_line;
        end
      end
    end

    out_d.ly          = line_d;
    out_d.mode        = mode_d;
    out_d.coincidence = coin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      line_q      <= '0;
      mode_q      <= lsmt_pkg::MODE_HBLANK;
      coin_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_d;
        line_q  <= line_d;
        mode_q  <= mode_d;
        coin_q  <= coin_d;
      end
      if (s_ready_o) begin
        out_valid_q <= s_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### src/lsmt_checker.sv
// ----------------------------------------------------------------------------
// lsmt_checker
// Port-level checks for the scanline timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmt_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire lsmt_pkg::out_word_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Layer and map selects only accompany a draw request.
  a_no_draw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.draw_request |->
      out_data_o.draw_layers == 3'd0 && !out_data_o.obj_tall &&
      out_data_o.region_select == 3'd0)
    else $error("draw fields set without draw request");

  // Draws only for visible lines other than line 0.
  a_draw_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.draw_request |->
      out_data_o.ly != 8'd0 && out_data_o.ly < lsmt_pkg::VblankLine &&
      !out_data_o.vblank_irq)
    else $error("draw request on a non-visible line");

  // Vblank pulse coincides with the move to line 144.
  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.vblank_irq |-> out_data_o.ly == lsmt_pkg::VblankLine)
    else $error("vblank pulse off line 144");

  // The line never passes the last line of the frame.
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.ly <= lsmt_pkg::LastLine)
    else $error("line beyond end of frame");

endmodule

bind lcd_scanline_mode_timer_top lsmt_checker u_lsmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
